// ----- sv/atilt_pkg.sv -----
// ----------------------------------------------------------------------------
// atilt_pkg
// shared widths, constants and the arctangent table for the tilt angle block
// ----------------------------------------------------------------------------
package atilt_pkg;

    localparam int SAMPLE_BITS  = 13;
    localparam int SUM_W        = SAMPLE_BITS + 8;
    localparam int MAG_W        = SUM_W - 1;
    localparam int COUNT_W      = 8;
    localparam int ANGLE_W      = 15;
    localparam int SQ_W         = 2 * SAMPLE_BITS - 1;
    localparam int DSQ_W        = SQ_W + 1;
    localparam int RAD_W        = DSQ_W + 30;
    localparam int ROOT_W       = RAD_W / 2;
    localparam int CORD_W       = 32;
    localparam int CORD_STEPS   = 20;
    localparam int QUARTER_TURN = 9000;
    localparam int COUNT_RESET  = 10;

    localparam logic [2:0] REG_AVG_COUNT = 3'd0;

    // arctangent of 2^-i in 0.01 degree units scaled by 2^16
    function automatic logic signed [CORD_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [CORD_W-1:0] v;
        begin
            case (i)
                5'd0:    v = 32'sd294912000;
                5'd1:    v = 32'sd174096719;
                5'd2:    v = 32'sd91987925;
                5'd3:    v = 32'sd46694507;
                5'd4:    v = 32'sd23437865;
                5'd5:    v = 32'sd11730358;
                5'd6:    v = 32'sd5866610;
                5'd7:    v = 32'sd2933484;
                5'd8:    v = 32'sd1466764;
                5'd9:    v = 32'sd733385;
                5'd10:   v = 32'sd366693;
                5'd11:   v = 32'sd183346;
                5'd12:   v = 32'sd91673;
                5'd13:   v = 32'sd45837;
                5'd14:   v = 32'sd22918;
                5'd15:   v = 32'sd11459;
                5'd16:   v = 32'sd5730;
                5'd17:   v = 32'sd2865;
                5'd18:   v = 32'sd1432;
                5'd19:   v = 32'sd716;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // arithmetic shift right that rounds toward zero
    function automatic logic signed [CORD_W-1:0] shr_trunc(
        input logic signed [CORD_W-1:0] v,
        input logic [4:0]               k
    );
        logic [CORD_W-1:0] m;
        begin
            m = v[CORD_W-1] ? (~v + 1'b1) : v;
            m = m >> k;
            return v[CORD_W-1] ? signed'(~m + 1'b1) : signed'(m);
        end
    endfunction

endpackage

// ----- sv/atilt_sample_if.sv -----
// ----------------------------------------------------------------------------
// atilt_sample_if
// input channel: one three-axis sample per item
// ----------------------------------------------------------------------------
interface atilt_sample_if
    import atilt_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;

    modport source (output valid, sample_x, sample_y, sample_z, input ready);
    modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

// ----- sv/atilt_result_if.sv -----
// ----------------------------------------------------------------------------
// atilt_result_if
// output channel: averages and tilt angles
// ----------------------------------------------------------------------------
interface atilt_result_if
    import atilt_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] avg_x;
    logic signed [SAMPLE_BITS-1:0] avg_y;
    logic signed [SAMPLE_BITS-1:0] avg_z;
    logic signed [ANGLE_W-1:0]     pitch_angle;
    logic signed [ANGLE_W-1:0]     roll_angle;

    modport source (output valid, avg_x, avg_y, avg_z, pitch_angle, roll_angle,
                    input ready);
    modport sink   (input valid, avg_x, avg_y, avg_z, pitch_angle, roll_angle,
                    output ready);
endinterface

// ----- sv/averaged_tilt_angle.sv -----
// ----------------------------------------------------------------------------
// averaged_tilt_angle
// averages three-axis samples and reports pitch and roll in 0.01 degree
// ----------------------------------------------------------------------------
//  channel      direction  handshake        payload
//  sample_in    in         valid / ready    sample_x, sample_y, sample_z
//  result_out   out        valid / ready    avg_x, avg_y, avg_z, pitch, roll
//  apb          in         psel / penable   avg_count at byte address 0
//
//  a sample that does not close a batch is only added to the sums
//  a closing sample goes through the serial divider once per axis,
//  then twice through the shared angle unit (28 root steps, 20 cordic steps)
//  the result sits in an output register; the next sample is taken while it waits
//  reset clears the sums and sample count and sets avg_count to 10
// ----------------------------------------------------------------------------
module averaged_tilt_angle
    import atilt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    atilt_sample_if.sink          sample_in,
    atilt_result_if.source        result_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_DIV_GO     = 3'd1;
    localparam logic [2:0] ST_DIV_WAIT   = 3'd2;
    localparam logic [2:0] ST_PITCH_GO   = 3'd3;
    localparam logic [2:0] ST_PITCH_WAIT = 3'd4;
    localparam logic [2:0] ST_ROLL_GO    = 3'd5;
    localparam logic [2:0] ST_ROLL_WAIT  = 3'd6;
    localparam logic [2:0] ST_OUT        = 3'd7;

    logic [2:0]                    state_reg, state_next;
    logic [1:0]                    axis_reg, axis_next;
    logic [COUNT_W-1:0]            count_reg, count_next;
    logic [COUNT_W-1:0]            taken_reg, taken_next;
    logic signed [SUM_W-1:0]       sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]       sum_y_reg, sum_y_next;
    logic signed [SUM_W-1:0]       sum_z_reg, sum_z_next;
    logic signed [SAMPLE_BITS-1:0] ax_reg, ax_next;
    logic signed [SAMPLE_BITS-1:0] ay_reg, ay_next;
    logic signed [SAMPLE_BITS-1:0] az_reg, az_next;
    logic signed [ANGLE_W-1:0]     pitch_reg, pitch_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] o_ax_reg, o_ay_reg, o_az_reg;
    logic signed [ANGLE_W-1:0]     o_pitch_reg, o_roll_reg;

    logic                          cfg_wr;
    logic                          take;
    logic                          load_out;
    logic [COUNT_W-1:0]            count_eff;
    logic [COUNT_W-1:0]            taken_inc;
    logic signed [SUM_W-1:0]       div_in;
    logic                          div_start, div_done;
    logic signed [SAMPLE_BITS-1:0] div_q;
    logic                          ang_start, ang_done;
    logic signed [SAMPLE_BITS-1:0] ang_num, ang_a, ang_b;
    logic signed [ANGLE_W-1:0]     ang_out;

    // register port: one register, writes restart the batch
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_AVG_COUNT[2]);
    assign prdata = (paddr[2] == REG_AVG_COUNT[2]) ? {24'b0, count_reg} : 32'b0;

    // a count of zero behaves as one
    assign count_eff = (count_reg == '0) ? COUNT_W'(1) : count_reg;
    assign taken_inc = taken_reg + COUNT_W'(1);

    assign sample_in.ready = (state_reg == ST_IDLE);
    assign take            = sample_in.valid && sample_in.ready;
    assign load_out        = (state_reg == ST_OUT) && (!out_valid_reg || result_out.ready);

    // divider works through the three sums, one axis per pass
    always_comb
    begin
        case (axis_reg)
            2'd0:    div_in = sum_x_reg;
            2'd1:    div_in = sum_y_reg;
            default: div_in = sum_z_reg;
        endcase
    end
    assign div_start = (state_reg == ST_DIV_GO);

    // pitch: x over yz plane, roll: y over xz plane
    assign ang_start = (state_reg == ST_PITCH_GO) || (state_reg == ST_ROLL_GO);
    assign ang_num   = (state_reg == ST_ROLL_GO) ? ay_reg : ax_reg;
    assign ang_a     = (state_reg == ST_ROLL_GO) ? ax_reg : ay_reg;
    assign ang_b     = az_reg;

    atilt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .divisor  (count_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    atilt_angle u_angle (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ang_start),
        .num   (ang_num),
        .den_a (ang_a),
        .den_b (ang_b),
        .done  (ang_done),
        .angle (ang_out)
    );

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        count_next     = count_reg;
        taken_next     = taken_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        sum_z_next     = sum_z_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        pitch_next     = pitch_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    sum_x_next = sum_x_reg + SUM_W'(sample_in.sample_x);
                    sum_y_next = sum_y_reg + SUM_W'(sample_in.sample_y);
                    sum_z_next = sum_z_reg + SUM_W'(sample_in.sample_z);
                    taken_next = taken_inc;
                    if (taken_inc >= count_eff)
                    begin
                        axis_next  = 2'd0;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_DIV_GO:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (axis_reg)
                        2'd0:    ax_next = div_q;
                        2'd1:    ay_next = div_q;
                        default: az_next = div_q;
                    endcase
                    if (axis_reg == 2'd2)
                        state_next = ST_PITCH_GO;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_PITCH_GO:
                state_next = ST_PITCH_WAIT;
            ST_PITCH_WAIT:
            begin
                if (ang_done)
                begin
                    pitch_next = ang_out;
                    state_next = ST_ROLL_GO;
                end
            end
            ST_ROLL_GO:
                state_next = ST_ROLL_WAIT;
            ST_ROLL_WAIT:
            begin
                if (ang_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    sum_x_next     = '0;
                    sum_y_next     = '0;
                    sum_z_next     = '0;
                    taken_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (cfg_wr)
        begin
            count_next = pwdata[COUNT_W-1:0];
            sum_x_next = '0;
            sum_y_next = '0;
            sum_z_next = '0;
            taken_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 2'd0;
            count_reg     <= COUNT_W'(COUNT_RESET);
            taken_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            count_reg     <= count_next;
            taken_reg     <= taken_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_z_reg     <= sum_z_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // averages, pitch and the output stage; roll is still held by the angle unit
    always_ff @(posedge clk)
    begin
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        az_reg    <= az_next;
        pitch_reg <= pitch_next;
        if (load_out)
        begin
            o_ax_reg    <= ax_reg;
            o_ay_reg    <= ay_reg;
            o_az_reg    <= az_reg;
            o_pitch_reg <= pitch_reg;
            o_roll_reg  <= ang_out;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.avg_x       = o_ax_reg;
    assign result_out.avg_y       = o_ay_reg;
    assign result_out.avg_z       = o_az_reg;
    assign result_out.pitch_angle = o_pitch_reg;
    assign result_out.roll_angle  = o_roll_reg;

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider done outside its wait state");

    // a register write always restarts the batch
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> taken_reg == '0 && sum_x_reg == '0)
        else $error("batch not cleared by register write");

    // angles stay within a quarter turn
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (o_pitch_reg <= 15'sd9000 && o_pitch_reg >= -15'sd9000
                                  && o_roll_reg <= 15'sd9000 && o_roll_reg >= -15'sd9000))
        else $error("angle out of range");

endmodule

// ----- sv/atilt_div.sv -----
// ----------------------------------------------------------------------------
// atilt_div
// bit-serial restoring divider, signed sum by unsigned count, toward zero
// ----------------------------------------------------------------------------
module atilt_div
    import atilt_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SUM_W-1:0]       dividend,
    input  logic [COUNT_W-1:0]            divisor,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [4:0]           iter_reg, iter_next;
    logic [MAG_W-1:0]     q_reg, q_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0]   dvs_reg, dvs_next;
    logic [COUNT_W:0]     trial;
    logic [SUM_W-1:0]     mag;
    logic [SAMPLE_BITS-1:0] qn;

    assign mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    assign trial = {rem_reg, q_reg[MAG_W-1]};
    assign qn    = q_reg[SAMPLE_BITS-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        iter_next = iter_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (!busy_reg && start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[SUM_W-1];
            q_next    = mag[MAG_W-1:0];
            rem_next  = '0;
            iter_next = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = COUNT_W'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[COUNT_W-1:0];
                q_next   = {q_reg[MAG_W-2:0], 1'b0};
            end
            iter_next = iter_reg + 5'd1;
            if (iter_reg == 5'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        iter_reg <= iter_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? signed'(~qn + 1'b1) : signed'(qn);

endmodule

// ----- sv/atilt_angle.sv -----
// ----------------------------------------------------------------------------
// atilt_angle
// atan(num / sqrt(a^2 + b^2)) by bit-serial square root and vectoring cordic
// ----------------------------------------------------------------------------
module atilt_angle
    import atilt_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] num,
    input  logic signed [SAMPLE_BITS-1:0] den_a,
    input  logic signed [SAMPLE_BITS-1:0] den_b,
    output logic                          done,
    output logic signed [ANGLE_W-1:0]     angle
);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_SQ   = 3'd1;
    localparam logic [2:0] A_SUM  = 3'd2;
    localparam logic [2:0] A_SQRT = 3'd3;
    localparam logic [2:0] A_CORD = 3'd4;
    localparam logic [2:0] A_FIN  = 3'd5;

    localparam logic signed [CORD_W-1:0] CZ_MAX = CORD_W'(QUARTER_TURN * 65536);

    logic [2:0]                    state_reg, state_next;
    logic                          done_reg, done_next;
    logic signed [SAMPLE_BITS-1:0] num_reg, num_next;
    logic signed [SAMPLE_BITS-1:0] a_reg, a_next;
    logic signed [SAMPLE_BITS-1:0] b_reg, b_next;
    logic [SQ_W-1:0]               sqa_reg, sqa_next;
    logic [SQ_W-1:0]               sqb_reg, sqb_next;
    logic [RAD_W-1:0]              rad_reg, rad_next;
    logic [ROOT_W-1:0]             root_reg, root_next;
    logic [ROOT_W:0]               rem_reg, rem_next;
    logic [4:0]                    iter_reg, iter_next;
    logic signed [CORD_W-1:0]      cx_reg, cx_next;
    logic signed [CORD_W-1:0]      cy_reg, cy_next;
    logic signed [CORD_W-1:0]      cz_reg, cz_next;
    logic signed [ANGLE_W-1:0]     angle_reg, angle_next;

    logic signed [2*SAMPLE_BITS-1:0] prod_a, prod_b;
    logic [DSQ_W-1:0]              dsq;
    logic [ROOT_W+2:0]             rem_sh, trial;
    logic [SAMPLE_BITS-1:0]        num_mag;
    logic signed [CORD_W-1:0]      sx, sy, cz_clamp, cz_round;
    logic [ANGLE_W-1:0]            ang_mag;

    assign prod_a  = a_reg * a_reg;
    assign prod_b  = b_reg * b_reg;
    assign dsq     = {1'b0, sqa_reg} + {1'b0, sqb_reg};
    assign rem_sh  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign num_mag = num_reg[SAMPLE_BITS-1] ? (~num_reg + 1'b1) : num_reg;
    assign sx      = shr_trunc(cx_reg, iter_reg);
    assign sy      = shr_trunc(cy_reg, iter_reg);

    always_comb
    begin
        if (cz_reg < 0)
            cz_clamp = '0;
        else if (cz_reg > CZ_MAX)
            cz_clamp = CZ_MAX;
        else
            cz_clamp = cz_reg;
    end
    assign cz_round = (cz_clamp + CORD_W'(32768)) >>> 16;
    assign ang_mag  = cz_round[ANGLE_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sqa_next   = sqa_reg;
        sqb_next   = sqb_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        iter_next  = iter_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        angle_next = angle_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    num_next   = num;
                    a_next     = den_a;
                    b_next     = den_b;
                    state_next = A_SQ;
                end
            end
            A_SQ:
            begin
                sqa_next   = prod_a[SQ_W-1:0];
                sqb_next   = prod_b[SQ_W-1:0];
                state_next = A_SUM;
            end
            A_SUM:
            begin
                if (dsq == '0)
                begin
                    // flat denominator: straight up, straight down or level
                    if (num_reg == '0)
                        angle_next = '0;
                    else if (num_reg[SAMPLE_BITS-1])
                        angle_next = -ANGLE_W'(QUARTER_TURN);
                    else
                        angle_next = ANGLE_W'(QUARTER_TURN);
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
                else if (num_reg == '0)
                begin
                    angle_next = '0;
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
                else
                begin
                    rad_next   = {dsq, 30'b0};
                    root_next  = '0;
                    rem_next   = '0;
                    iter_next  = '0;
                    state_next = A_SQRT;
                end
            end
            A_SQRT:
            begin
                // two radicand bits per cycle
                if (rem_sh >= trial)
                begin
                    rem_next  = (ROOT_W+1)'(rem_sh - trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[ROOT_W:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(ROOT_W - 1))
                begin
                    iter_next  = '0;
                    state_next = A_CORD;
                end
            end
            A_CORD:
            begin
                if (!cy_reg[CORD_W-1])
                begin
                    cx_next = cx_reg + sy;
                    cy_next = cy_reg - sx;
                    cz_next = cz_reg + atan_entry(iter_reg);
                end
                else
                begin
                    cx_next = cx_reg - sy;
                    cy_next = cy_reg + sx;
                    cz_next = cz_reg - atan_entry(iter_reg);
                end
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(CORD_STEPS - 1))
                    state_next = A_FIN;
            end
            A_FIN:
            begin
                angle_next = num_reg[SAMPLE_BITS-1] ? signed'(~ang_mag + 1'b1)
                                                    : signed'(ang_mag);
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
                state_next = A_IDLE;
        endcase
        // load the cordic start vector as the root finishes
        if (state_reg == A_SQRT && iter_reg == 5'(ROOT_W - 1))
        begin
            cx_next = CORD_W'(root_next);
            cy_next = CORD_W'({num_mag, 15'b0});
            cz_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        sqa_reg   <= sqa_next;
        sqb_reg   <= sqb_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        rem_reg   <= rem_next;
        iter_reg  <= iter_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

// ----- bench/averaged_tilt_angle_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// averaged_tilt_angle_test
// feeds accelerometer samples through the tilt block under several averaging
// counts and idle patterns, predicts each averaged result with a local cordic
// model and compares every field of every result item
// ----------------------------------------------------------------------------
module averaged_tilt_angle_test;
    import atilt_pkg::*;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] x;
        logic signed [SAMPLE_BITS-1:0] y;
        logic signed [SAMPLE_BITS-1:0] z;
    } sample_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] ax;
        logic signed [SAMPLE_BITS-1:0] ay;
        logic signed [SAMPLE_BITS-1:0] az;
        logic signed [ANGLE_W-1:0]     pitch;
        logic signed [ANGLE_W-1:0]     roll;
    } tilt_t;

    // idle patterns: percent of cycles the sender idles / the receiver stalls
    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

    localparam longint CYCLE_LIMIT = 4_000_000;
    // a closing sample runs the divider and the angle unit; allow margin after the last item
    localparam int     DRAIN_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    atilt_sample_if sample_ch ();
    atilt_result_if result_ch ();

    averaged_tilt_angle dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_ch.sink),
        .result_out (result_ch.source),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // predictor state
    longint      acc_x, acc_y, acc_z;
    int unsigned acc_n;
    int unsigned batch_len;

    sample_t     pending_samples[$];
    tilt_t       expected_tilts[$];

    idle_mode_t  idle_mode;
    bit          hold_off;          // long receiver stall
    bit          sample_taken = 1'b0;  // offered item accepted at the last rising edge
    int          hold_cycles;
    int          errors;
    int          results_seen;
    int          samples_sent;
    longint      cycle_count;

    // table angles of atan(2^-i), 0.01 degree scaled by 2^16
    longint atan_tab[CORD_STEPS] = '{
        294912000, 174096719, 91987925, 46694507, 23437865,
        11730358, 5866610, 2933484, 1466764, 733385,
        366693, 183346, 91673, 45837, 22918,
        11459, 5730, 2865, 1432, 716
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic longint trunc_shift(longint v, int k);
        if (v < 0)
            return -((-v) >>> k);
        return v >>> k;
    endfunction

    // integer square root by bit pairs
    function automatic longint int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned one;
        res = 0;
        one = 64'd1 << 62;
        while (one > v)
            one = one >> 2;
        while (one != 0)
        begin
            if (v >= res + one)
            begin
                v   = v - (res + one);
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one = one >> 2;
        end
        return longint'(res);
    endfunction

    // atan(num / sqrt(den_sq)) in 0.01 degree
    function automatic longint tilt_of(longint num, longint den_sq);
        longint mag, cx, cy, cz, nx;
        if (den_sq == 0)
            return num > 0 ? QUARTER_TURN : (num < 0 ? -QUARTER_TURN : 0);
        mag = num < 0 ? -num : num;
        if (mag == 0)
            return 0;
        cx = int_root(longint'(den_sq) << 30);
        cy = mag * 32768;
        cz = 0;
        for (int i = 0; i < CORD_STEPS; i++)
        begin
            if (cy >= 0)
            begin
                nx = cx + trunc_shift(cy, i);
                cy = cy - trunc_shift(cx, i);
                cz += atan_tab[i];
            end
            else
            begin
                nx = cx - trunc_shift(cy, i);
                cy = cy + trunc_shift(cx, i);
                cz -= atan_tab[i];
            end
            cx = nx;
        end
        if (cz < 0)
            cz = 0;
        if (cz > longint'(QUARTER_TURN) * 65536)
            cz = longint'(QUARTER_TURN) * 65536;
        cz = (cz + 32768) / 65536;
        return num < 0 ? -cz : cz;
    endfunction

    // add one accepted sample; close the batch when the count is reached
    function automatic void accumulate_sample(sample_t s);
        int unsigned n;
        longint      ax, ay, az;
        tilt_t       t;
        n = batch_len == 0 ? 1 : batch_len;
        acc_x += s.x;
        acc_y += s.y;
        acc_z += s.z;
        acc_n++;
        if (acc_n < n)
            return;
        ax = acc_x / longint'(n);
        ay = acc_y / longint'(n);
        az = acc_z / longint'(n);
        t.ax    = ax[SAMPLE_BITS-1:0];
        t.ay    = ay[SAMPLE_BITS-1:0];
        t.az    = az[SAMPLE_BITS-1:0];
        t.pitch = ANGLE_W'(tilt_of(ax, ay * ay + az * az));
        t.roll  = ANGLE_W'(tilt_of(ay, ax * ax + az * az));
        expected_tilts.push_back(t);
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        acc_n = 0;
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued samples, changes inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!sample_ch.valid || sample_taken)
            begin
                // the offered item (if any) was taken at the last rising edge
                if (pending_samples.size() > 0 &&
                    !((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)
                      && $urandom_range(99) < 62))
                begin
                    sample_ch.valid    <= 1'b1;
                    sample_ch.sample_x <= pending_samples[0].x;
                    sample_ch.sample_y <= pending_samples[0].y;
                    sample_ch.sample_z <= pending_samples[0].z;
                    pending_samples.pop_front();
                end
                else
                    sample_ch.valid <= 1'b0;
            end
            if (hold_off)
                result_ch.ready <= 1'b0;
            else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
                result_ch.ready <= ($urandom_range(99) >= 62);
            else
                result_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: samples handshakes on the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            sample_taken <= sample_ch.valid && sample_ch.ready;
            if (sample_ch.valid && sample_ch.ready)
            begin
                sample_t s;
                s.x = sample_ch.sample_x;
                s.y = sample_ch.sample_y;
                s.z = sample_ch.sample_z;
                accumulate_sample(s);
                samples_sent++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                tilt_t e;
                results_seen++;
                if (expected_tilts.size() == 0)
                begin
                    $error("result item with none expected");
                    errors++;
                end
                else
                begin
                    e = expected_tilts.pop_front();
                    if (result_ch.avg_x !== e.ax)
                    begin
                        $error("avg_x expected %0d got %0d", e.ax, result_ch.avg_x);
                        errors++;
                    end
                    if (result_ch.avg_y !== e.ay)
                    begin
                        $error("avg_y expected %0d got %0d", e.ay, result_ch.avg_y);
                        errors++;
                    end
                    if (result_ch.avg_z !== e.az)
                    begin
                        $error("avg_z expected %0d got %0d", e.az, result_ch.avg_z);
                        errors++;
                    end
                    if (result_ch.pitch_angle !== e.pitch)
                    begin
                        $error("pitch_angle expected %0d got %0d",
                               e.pitch, result_ch.pitch_angle);
                        errors++;
                    end
                    if (result_ch.roll_angle !== e.roll)
                    begin
                        $error("roll_angle expected %0d got %0d",
                               e.roll, result_ch.roll_angle);
                        errors++;
                    end
                end
            end
        end
    end

    // long receiver stall, counted here so the sender keeps pushing
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_off    <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            hold_off <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // configuration access (only while the block is idle)
    // ------------------------------------------------------------------
    task automatic write_count(logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_AVG_COUNT;
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // a write restarts accumulation
        batch_len = value;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        acc_n = 0;
    endtask

    // wait until every queued sample went in and every result came out
    task automatic drain();
        while (pending_samples.size() > 0 || sample_ch.valid ||
               expected_tilts.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_axis();
        case ($urandom_range(9))
            0:       return -13'sd4096;
            1:       return 13'sd4095;
            2:       return '0;
            3:       return SAMPLE_BITS'($urandom_range(7)) - 13'sd3;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic void queue_sample(int x, int y, int z);
        sample_t s;
        s.x = SAMPLE_BITS'(x);
        s.y = SAMPLE_BITS'(y);
        s.z = SAMPLE_BITS'(z);
        pending_samples.push_back(s);
    endfunction

    // one phase of random samples under a count and idle pattern
    task automatic random_phase(logic [7:0] count, idle_mode_t mode, int n);
        int cx, cy, cz;
        write_count(count);
        idle_mode = mode;
        // a steady tilt with noise gives realistic averages; the rest is raw
        cx = rand_axis();
        cy = rand_axis();
        cz = rand_axis();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                queue_sample(rand_axis(), rand_axis(), rand_axis());
            else
                queue_sample(cx, cy, cz);
        end
        drain();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample_x = '0;
        sample_ch.sample_y = '0;
        sample_ch.sample_z = '0;
        result_ch.ready = 1'b0;
        idle_mode       = IDLE_NONE;
        hold_off        = 1'b0;
        hold_cycles     = 0;
        errors          = 0;
        results_seen    = 0;
        samples_sent    = 0;
        cycle_count     = 0;
        batch_len       = COUNT_RESET;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        acc_n = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset count of 10, extremes and zero denominators
        for (int i = 0; i < 10; i++)
            queue_sample(-4096, 4095, -4096);
        drain();
        write_count(8'd1);
        queue_sample(0, 0, 0);          // both angles zero
        queue_sample(4095, 0, 0);       // pitch +90, roll zero
        queue_sample(-4096, 0, 0);      // pitch -90
        queue_sample(0, -4096, 0);      // roll -90
        queue_sample(0, 4095, 0);       // roll +90
        queue_sample(0, 0, 4095);
        queue_sample(4095, 4095, 4095);
        queue_sample(-4096, -4096, -4096);
        queue_sample(1, -1, 0);
        queue_sample(-1, 0, 1);
        queue_sample(2730, -5, 1365);
        drain();
        // count of zero acts as one
        write_count(8'd0);
        queue_sample(-7, 3, 4095);
        queue_sample(4095, -4096, 1);
        drain();
        // truncation toward zero on negative sums
        write_count(8'd3);
        queue_sample(-1, 1, -2);
        queue_sample(0, 0, 0);
        queue_sample(0, 1, 0);
        drain();

        // random phases over counts and idle patterns
        random_phase(8'd1,   IDLE_NONE, 150);
        random_phase(8'd2,   IDLE_SEND, 150);
        random_phase(8'd3,   IDLE_RECV, 150);
        random_phase(8'd1,   IDLE_BOTH, 150);
        random_phase(8'd255, IDLE_NONE, 255);
        random_phase(8'($urandom_range(4, 9)), IDLE_BOTH, 275);

        // long stall on the result side while samples keep coming
        write_count(8'd1);
        idle_mode   = IDLE_NONE;
        hold_cycles = 2000;
        for (int i = 0; i < 40; i++)
            queue_sample(rand_axis(), rand_axis(), rand_axis());
        drain();

        // write mid-batch (block idle, partial sums) restarts accumulation
        write_count(8'd5);
        queue_sample(100, 200, 300);
        queue_sample(100, 200, 300);
        drain();
        write_count(8'd2);
        queue_sample(-4096, 4095, 0);
        queue_sample(-4096, 4095, 0);
        drain();

        $display("covered %0d samples and %0d averaged results over counts 0..255",
                 samples_sent, results_seen);
        $display("idle patterns: none, sender, receiver, both, plus a long stall");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
